@@ sv/miller_rabin_prime_test_64_core_macros.svh @@
// Assertion macros for the Miller-Rabin prime test core.
// Needs clk and rst_n in scope at the point of use.
`ifndef MILLER_RABIN_PRIME_TEST_64_CORE_MACROS_SVH
`define MILLER_RABIN_PRIME_TEST_64_CORE_MACROS_SVH

// same-cycle implication
`define MRPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MRPT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/mrpt_pkg.sv @@
// Shared types, constants and base tables for the Miller-Rabin prime test core.
// No dependencies.
package mrpt_pkg;

    localparam int MOD_BITS_DEF    = 64;
    localparam int SHORT_BITS      = 32;
    localparam int SHORT_LIMIT_LOG = 31;
    localparam int LONG_BASE_CNT   = 7;
    localparam int SHORT_BASE_CNT  = 3;

    typedef enum logic {
        MOP_PLAIN,
        MOP_MONT
    } mrpt_op_t;

    typedef struct packed {
        logic     go;
        mrpt_op_t op;
        logic     wide;
    } mrpt_req_t;

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_MUL,
        MS_FIN
    } mrpt_mstate_t;

    typedef enum logic [1:0] {
        PH_AB,
        PH_MI,
        PH_MN
    } mrpt_phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_INV_T,
        ST_INV_X,
        ST_R2,
        ST_STRIP,
        ST_ONE,
        ST_REV,
        ST_BASE,
        ST_POW,
        ST_POW_SQ,
        ST_SQ
    } mrpt_state_t;

    function automatic logic [63:0] base_value(input logic wide, input logic [2:0] k);
        logic [63:0] v;
        v = '0;
        if (wide)
        begin
            unique case (k)
                3'd0:    v = 64'd2;
                3'd1:    v = 64'd325;
                3'd2:    v = 64'd9375;
                3'd3:    v = 64'd28178;
                3'd4:    v = 64'd450775;
                3'd5:    v = 64'd9780504;
                3'd6:    v = 64'd1795265022;
                default: v = '0;
            endcase
        end
        else
        begin
            unique case (k)
                3'd0:    v = 64'd2;
                3'd1:    v = 64'd7;
                3'd2:    v = 64'd61;
                default: v = '0;
            endcase
        end
        return v;
    endfunction

endpackage

@@ sv/miller_rabin_prime_test_64_core.sv @@
// Top level of the deterministic Miller-Rabin prime test for 64-bit numbers.
// Sequencer around mrpt_mont; depends on mrpt_pkg and the macros header.
//
//  channel   ports                      handshake
//  input     candidate                  taken when start && !busy
//  result    prime_flag                 valid for one cycle while done is high
//
// The run time of one transaction is shortest for the trivial cases and longest for
// seven bases near 2^64; the cost is set by the Montgomery multiplier, working on its
// single 32x32 multiplier, plus the computation of R^2.
// busy stays high from acceptance until done. Reset clears all control state.
// The receiver cannot stall: done is a single-cycle strobe.
`include "miller_rabin_prime_test_64_core_macros.svh"

module miller_rabin_prime_test_64_core
    import mrpt_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] candidate,
    output logic        done,
    output logic        prime_flag
);

    localparam logic [6:0] W_WIDE   = 7'(MOD_BITS);
    localparam logic [6:0] W_SHORT  = 7'(SHORT_BITS);
    localparam logic [6:0] R2_WIDE  = 7'(2 * MOD_BITS - 1);
    localparam logic [6:0] R2_SHORT = 7'(2 * SHORT_BITS - 1);

    mrpt_state_t state_reg, state_next;
    logic        wait_reg, wait_next;
    logic [63:0] n_reg, n_next;
    logic        wide_reg, wide_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] t_reg, t_next;
    logic [6:0]  bits_reg, bits_next;
    logic [63:0] r_reg, r_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] d_reg, d_next;
    logic [63:0] one_reg, one_next;
    logic [63:0] rev_reg, rev_next;
    logic [2:0]  k_reg, k_next;
    logic [63:0] base_reg, base_next;
    logic [63:0] e_reg, e_next;
    logic [63:0] y_reg, y_next;
    logic        flag_reg, flag_next;
    logic        done_reg, done_next;

    mrpt_req_t   mont_req;
    logic [63:0] mont_a, mont_b, mont_res;
    logic        mont_done;

    logic [63:0] nm1, diff, base_a;
    logic [6:0]  w_sel, r2_last;
    logic [2:0]  base_cnt;

    mrpt_mont #(
        .MOD_BITS (MOD_BITS)
    ) u_mont (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mont_req),
        .op_a    (mont_a),
        .op_b    (mont_b),
        .modulus (n_reg),
        .inverse (x_reg),
        .done    (mont_done),
        .result  (mont_res)
    );

    always_comb
    begin
        nm1      = n_reg - 64'd1;
        diff     = n_reg - r_reg;
        w_sel    = wide_reg ? W_WIDE : W_SHORT;
        r2_last  = wide_reg ? R2_WIDE : R2_SHORT;
        base_cnt = wide_reg ? 3'(LONG_BASE_CNT) : 3'(SHORT_BASE_CNT);
        base_a   = base_value(wide_reg, k_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        wait_next  = wait_reg;
        n_next     = n_reg;
        wide_next  = wide_reg;
        x_next     = x_reg;
        t_next     = t_reg;
        bits_next  = bits_reg;
        r_next     = r_reg;
        cnt_next   = cnt_reg;
        d_next     = d_reg;
        one_next   = one_reg;
        rev_next   = rev_reg;
        k_next     = k_reg;
        base_next  = base_reg;
        e_next     = e_reg;
        y_next     = y_reg;
        flag_next  = flag_reg;
        done_next  = 1'b0;
        mont_req   = '{go: 1'b0, op: MOP_MONT, wide: wide_reg};
        mont_a     = '0;
        mont_b     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next     = candidate;
                    wait_next  = 1'b0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                x_next    = 64'd1;
                bits_next = 7'd1;
                if (n_reg == 64'd2)
                begin
                    flag_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (n_reg < 64'd2 || !n_reg[0])
                begin
                    flag_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (n_reg[63:SHORT_LIMIT_LOG] == '0)
                begin
                    wide_next  = 1'b0;
                    state_next = ST_INV_T;
                end
                else if ((n_reg >> MOD_BITS) != 64'd0)
                begin
                    flag_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    wide_next  = 1'b1;
                    state_next = ST_INV_T;
                end
            end
            ST_INV_T:
            begin
                mont_req.op = MOP_PLAIN;
                mont_a      = x_reg;
                mont_b      = n_reg;
                if (wait_reg)
                begin
                    if (mont_done)
                    begin
                        wait_next  = 1'b0;
                        t_next     = mont_res;
                        state_next = ST_INV_X;
                    end
                end
                else if (bits_reg >= w_sel)
                begin
                    r_next     = 64'd1;
                    cnt_next   = '0;
                    state_next = ST_R2;
                end
                else
                begin
                    mont_req.go = 1'b1;
                    wait_next   = 1'b1;
                end
            end
            ST_INV_X:
            begin
                mont_req.op = MOP_PLAIN;
                mont_a      = x_reg;
                mont_b      = 64'd2 - t_reg;
                if (wait_reg)
                begin
                    if (mont_done)
                    begin
                        wait_next  = 1'b0;
                        x_next     = mont_res;
                        bits_next  = bits_reg << 1;
                        state_next = ST_INV_T;
                    end
                end
                else
                begin
                    mont_req.go = 1'b1;
                    wait_next   = 1'b1;
                end
            end
            ST_R2:
            begin
                r_next   = (r_reg >= diff) ? (r_reg - diff) : (r_reg << 1);
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == r2_last)
                begin
                    d_next     = nm1;
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP:
            begin
                if (!d_reg[0])
                begin
                    d_next = d_reg >> 1;
                end
                else
                begin
                    state_next = ST_ONE;
                end
            end
            ST_ONE:
            begin
                mont_a = 64'd1;
                mont_b = r_reg;
                if (wait_reg)
                begin
                    if (mont_done)
                    begin
                        wait_next  = 1'b0;
                        one_next   = mont_res;
                        state_next = ST_REV;
                    end
                end
                else
                begin
                    mont_req.go = 1'b1;
                    wait_next   = 1'b1;
                end
            end
            ST_REV:
            begin
                mont_a = nm1;
                mont_b = r_reg;
                if (wait_reg)
                begin
                    if (mont_done)
                    begin
                        wait_next  = 1'b0;
                        rev_next   = mont_res;
                        k_next     = '0;
                        state_next = ST_BASE;
                    end
                end
                else
                begin
                    mont_req.go = 1'b1;
                    wait_next   = 1'b1;
                end
            end
            ST_BASE:
            begin
                mont_a = base_a;
                mont_b = r_reg;
                if (wait_reg)
                begin
                    if (mont_done)
                    begin
                        wait_next  = 1'b0;
                        base_next  = mont_res;
                        y_next     = one_reg;
                        e_next     = d_reg;
                        state_next = ST_POW;
                    end
                end
                else if (k_reg == base_cnt || n_reg <= base_a)
                begin
                    flag_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    mont_req.go = 1'b1;
                    wait_next   = 1'b1;
                end
            end
            ST_POW:
            begin
                mont_a = y_reg;
                mont_b = base_reg;
                if (wait_reg)
                begin
                    if (mont_done)
                    begin
                        wait_next  = 1'b0;
                        y_next     = mont_res;
                        state_next = ST_POW_SQ;
                    end
                end
                else if (e_reg == 64'd0)
                begin
                    t_next     = d_reg;
                    state_next = ST_SQ;
                end
                else if (e_reg[0])
                begin
                    mont_req.go = 1'b1;
                    wait_next   = 1'b1;
                end
                else
                begin
                    state_next = ST_POW_SQ;
                end
            end
            ST_POW_SQ:
            begin
                mont_a = base_reg;
                mont_b = base_reg;
                if (wait_reg)
                begin
                    if (mont_done)
                    begin
                        wait_next  = 1'b0;
                        base_next  = mont_res;
                        e_next     = e_reg >> 1;
                        state_next = ST_POW;
                    end
                end
                else
                begin
                    mont_req.go = 1'b1;
                    wait_next   = 1'b1;
                end
            end
            ST_SQ:
            begin
                mont_a = y_reg;
                mont_b = y_reg;
                if (wait_reg)
                begin
                    if (mont_done)
                    begin
                        wait_next = 1'b0;
                        y_next    = mont_res;
                        t_next    = t_reg << 1;
                    end
                end
                else if (t_reg != nm1 && y_reg != one_reg && y_reg != rev_reg)
                begin
                    mont_req.go = 1'b1;
                    wait_next   = 1'b1;
                end
                else if (y_reg != rev_reg && !t_reg[0])
                begin
                    flag_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 3'd1;
                    state_next = ST_BASE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wait_reg  <= 1'b0;
            done_reg  <= 1'b0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            done_reg  <= done_next;
            flag_reg  <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        wide_reg <= wide_next;
        x_reg    <= x_next;
        t_reg    <= t_next;
        bits_reg <= bits_next;
        r_reg    <= r_next;
        cnt_reg  <= cnt_next;
        d_reg    <= d_next;
        one_reg  <= one_next;
        rev_reg  <= rev_next;
        k_reg    <= k_next;
        base_reg <= base_next;
        e_reg    <= e_next;
        y_reg    <= y_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign prime_flag = flag_reg;

    `MRPT_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while sequencer busy")
    `MRPT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction not started")
    `MRPT_ASSERT_IMP(a_mont_expected, mont_done, wait_reg, "unrequested multiplier completion")

endmodule

@@ sv/mrpt_mont.sv @@
// Montgomery multiplier built on one 32x32 multiplier, four partial products per
// 64x64 product. Also does a plain 64-bit low product. Depends on mrpt_pkg.
module mrpt_mont
    import mrpt_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  mrpt_req_t   req,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    input  logic [63:0] modulus,
    input  logic [63:0] inverse,
    output logic        done,
    output logic [63:0] result
);

    localparam logic [63:0] WIDE_MASK  = {64{1'b1}} >> (64 - MOD_BITS);
    localparam logic [63:0] SHORT_MASK = {64{1'b1}} >> (64 - SHORT_BITS);

    mrpt_mstate_t state_reg, state_next;
    mrpt_phase_t  phase_reg, phase_next;
    mrpt_op_t     op_reg, op_next;
    logic         wide_reg, wide_next;
    logic [1:0]   step_reg, step_next;
    logic [63:0]  x_reg, x_next;
    logic [63:0]  y_reg, y_next;
    logic [127:0] acc_reg, acc_next;
    logic [127:0] p_reg, p_next;
    logic [63:0]  result_reg, result_next;
    logic         done_reg, done_next;

    logic [31:0]  xh, yh;
    logic [63:0]  pp;
    logic [6:0]   shamt;
    logic [127:0] pp_sh, sum;
    logic [63:0]  mask, top, sub, red;
    logic [127:0] top_w, sub_w;

    always_comb
    begin
        xh    = step_reg[0] ? x_reg[63:32] : x_reg[31:0];
        yh    = step_reg[1] ? y_reg[63:32] : y_reg[31:0];
        pp    = xh * yh;
        shamt = ({6'd0, step_reg[0]} + {6'd0, step_reg[1]}) << 5;
        pp_sh = {64'd0, pp} << shamt;
        sum   = acc_reg + pp_sh;
        mask  = wide_reg ? WIDE_MASK : SHORT_MASK;
        top_w = wide_reg ? (p_reg >> MOD_BITS) : (p_reg >> SHORT_BITS);
        sub_w = wide_reg ? (acc_reg >> MOD_BITS) : (acc_reg >> SHORT_BITS);
        top   = top_w[63:0];
        sub   = sub_w[63:0];
        red   = (top < sub) ? (top - sub + modulus) : (top - sub);
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        op_next     = op_reg;
        wide_next   = wide_reg;
        step_next   = step_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        acc_next    = acc_reg;
        p_next      = p_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            MS_IDLE:
            begin
                if (req.go)
                begin
                    x_next     = op_a;
                    y_next     = op_b;
                    acc_next   = '0;
                    step_next  = '0;
                    phase_next = PH_AB;
                    op_next    = req.op;
                    wide_next  = req.wide;
                    state_next = MS_MUL;
                end
            end
            MS_MUL:
            begin
                acc_next  = sum;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    unique case (phase_reg)
                        PH_AB:
                        begin
                            if (op_reg == MOP_PLAIN)
                            begin
                                result_next = sum[63:0];
                                done_next   = 1'b1;
                                state_next  = MS_IDLE;
                            end
                            else
                            begin
                                p_next     = sum;
                                x_next     = sum[63:0];
                                y_next     = inverse;
                                acc_next   = '0;
                                phase_next = PH_MI;
                            end
                        end
                        PH_MI:
                        begin
                            x_next     = sum[63:0] & mask;
                            y_next     = modulus;
                            acc_next   = '0;
                            phase_next = PH_MN;
                        end
                        PH_MN:
                        begin
                            state_next = MS_FIN;
                        end
                        default:
                        begin
                            state_next = MS_IDLE;
                        end
                    endcase
                end
            end
            MS_FIN:
            begin
                result_next = red;
                done_next   = 1'b1;
                state_next  = MS_IDLE;
            end
            default:
            begin
                state_next = MS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg  <= phase_next;
        op_reg     <= op_next;
        wide_reg   <= wide_next;
        step_reg   <= step_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        acc_reg    <= acc_next;
        p_reg      <= p_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
